@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked at every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ sv/sha_pkg.sv @@
// Package with SHA-256 constants, types and helper functions.
`default_nettype none
package sha_pkg;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds = 64;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } t_cmd;

    typedef logic [31:0] t_word;
    typedef t_word [7:0] t_hash;

    localparam t_hash InitHash = '{
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

    function automatic t_word round_k(input logic [5:0] i);
        t_word k;
        begin
            unique case (i)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = '0;
            endcase
            return k;
        end
    endfunction

    function automatic t_word ror32(input t_word v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction
endpackage
`default_nettype wire

@@ sv/sha_queue.sv @@
// Small queue of classified input beats between front and back.
`default_nettype none
module sha_queue
    import sha_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_data,
    output logic      o_empty
);
    t_cmd       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'd0, i_push} - {2'd0, i_pop};
        end
    end
endmodule
`default_nettype wire

@@ sv/sha_core.sv @@
// Back end: block gathering, padding, 64-round compression and digest output.
`default_nettype none
`include "assert_macros.svh"
module sha_core
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_word,
    output logic [2:0]       o_index,
    output logic             o_last
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_LAST, ST_PAD, ST_ROUND, ST_ADD, ST_EMIT
    } t_state;

    t_state       r_state;
    t_hash        r_hash;
    t_word        r_w [16];
    t_word        r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [5:0]   r_fill;
    logic [5:0]   r_round;
    logic [60:0]  r_count;
    logic         r_final;
    logic         r_last_pend;
    logic         r_pad;
    logic         r_zero_wrap;
    logic [2:0]   r_idx;

    t_word        w_cur, w_new, s0w, s1w, s1, ch, t1, s0, mj;
    logic [63:0]  bits;
    logic [7:0]   pad_byte;
    logic [5:0]   fill_inc;

    assign bits     = {r_count, 3'b000};
    assign fill_inc = r_fill + 6'd1;

    // The length goes into bytes 56 to 63 unless the end marker already sits past byte 55.
    always_comb begin
        if (r_fill >= LenStart && !r_zero_wrap) begin
            pad_byte = bits[{~r_fill[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = '0;
        end
    end

    // Message schedule as a 16-word shift window.
    assign s0w   = ror32(r_w[1], 7) ^ ror32(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1w   = ror32(r_w[14], 17) ^ ror32(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = r_w[0] + s0w + r_w[9] + s1w;
    assign w_cur = r_w[0];
    assign s1 = ror32(r_e, 6) ^ ror32(r_e, 11) ^ ror32(r_e, 25);
    assign ch = (r_e & r_f) ^ (~r_e & r_g);
    assign t1 = r_h + s1 + ch + round_k(r_round) + w_cur;
    assign s0 = ror32(r_a, 2) ^ ror32(r_a, 13) ^ ror32(r_a, 22);
    assign mj = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);

    assign o_cmd_pop   = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_word      = r_hash[r_idx];
    assign o_index     = r_idx;
    assign o_last      = (r_idx == 3'd7);

    task automatic put_byte(input logic [7:0] v);
        begin
            r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= v;
            r_fill <= fill_inc;
        end
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hash      <= InitHash;
            r_fill      <= '0;
            r_count     <= '0;
            r_round     <= '0;
            r_final     <= 1'b0;
            r_last_pend <= 1'b0;
            r_pad       <= 1'b0;
            r_zero_wrap <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_state != ST_ROUND) begin
                {r_a, r_b, r_c, r_d} <= {r_hash[0], r_hash[1], r_hash[2], r_hash[3]};
                {r_e, r_f, r_g, r_h} <= {r_hash[4], r_hash[5], r_hash[6], r_hash[7]};
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.has_byte) begin
                            r_count <= r_count + 61'd1;
                            put_byte(i_cmd.data_byte);
                            if (fill_inc == 6'd0) begin
                                r_state     <= ST_ROUND;
                                r_last_pend <= i_cmd.is_last;
                            end else if (i_cmd.is_last) begin
                                r_state <= ST_LAST;
                            end
                        end else if (i_cmd.is_last) begin
                            r_state <= ST_LAST;
                        end
                        r_round <= '0;
                    end
                end
                ST_LAST: begin
                    put_byte(PadByte);
                    r_state     <= (fill_inc == 6'd0) ? ST_ROUND : ST_PAD;
                    r_last_pend <= 1'b0;
                    r_pad       <= 1'b1;
                    r_zero_wrap <= (r_fill >= LenStart) && (fill_inc != 6'd0);
                end
                ST_PAD: begin
                    put_byte(pad_byte);
                    if (fill_inc == 6'd0) begin
                        r_state     <= ST_ROUND;
                        r_final     <= !r_zero_wrap;
                        r_zero_wrap <= 1'b0;
                    end
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i + 1];
                    end
                    r_w[15] <= w_new;
                    r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
                    r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + s0 + mj;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'(Rounds - 1)) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_hash[0] <= r_hash[0] + r_a; r_hash[1] <= r_hash[1] + r_b;
                    r_hash[2] <= r_hash[2] + r_c; r_hash[3] <= r_hash[3] + r_d;
                    r_hash[4] <= r_hash[4] + r_e; r_hash[5] <= r_hash[5] + r_f;
                    r_hash[6] <= r_hash[6] + r_g; r_hash[7] <= r_hash[7] + r_h;
                    r_round <= '0;
                    r_idx   <= '0;
                    if (r_final) begin
                        r_state <= ST_EMIT;
                    end else if (r_last_pend) begin
                        r_state <= ST_LAST;
                    end else if (r_pad) begin
                        r_state <= ST_PAD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (i_out_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_state     <= ST_IDLE;
                            r_hash      <= InitHash;
                            r_fill      <= '0;
                            r_count     <= '0;
                            r_final     <= 1'b0;
                            r_pad       <= 1'b0;
                            r_zero_wrap <= 1'b0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_emit_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_index))
    `ASSERT_IMPL(a_no_pop_busy, i_clk, i_rst_n, o_cmd_pop, r_state == ST_IDLE)
    `ASSERT_NEXT(a_round_end, i_clk, i_rst_n, r_state == ST_ROUND && r_round == 6'd63, r_state == ST_ADD)
endmodule
`default_nettype wire

@@ sv/sha256_stream_hasher_top.sv @@
// Top level of the byte-stream SHA-256 hasher.
// Usage: each slave beat carries one byte (tdata), has_byte (tuser) and is_last (tlast).
// A beat with tlast ends the message: padding is added, then eight master beats
// carry the digest words, word 0 (most significant) first, tlast on word 7.
// The front queue holds up to four beats, so input is taken while the core works.
// The core absorbs one byte per cycle into the block while idle with a queued beat;
// a full block is then compressed in the single shared round unit and the final add
// follows; no new beats are taken until the core is back in its idle state.
// A finish writes the padding at one byte per cycle and compresses one or two
// more blocks; the digest beats then leave one per cycle while m_axis_tready is high.
// The first digest beat waits for the padding and the last compression; beats still
// waiting in the queue are taken by the core only after the digest has left.
// A stalled receiver holds the digest beat; the core then stops and the queue
// fills, after which s_axis_tready falls.
// Reset clears the queue, the counters and loads the initial hash values.
`default_nettype none
`include "assert_macros.svh"
module sha256_stream_hasher_top
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  wire logic        s_axis_tuser,   // has_byte
    input  wire logic        s_axis_tlast,   // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // digest_word[31:0], word_index[34:32], zeros
    output logic             m_axis_tlast    // last_word
);
    t_cmd       cmd_in, cmd_out;
    logic       q_full, q_empty, pop;
    logic [31:0] word;
    logic [2:0]  index;

    assign cmd_in = '{data_byte: s_axis_tdata, has_byte: s_axis_tuser, is_last: s_axis_tlast};
    assign s_axis_tready = !q_full;

    // Beats without a byte and without tlast carry no work and are dropped here.
    sha_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid && !q_full && (s_axis_tuser || s_axis_tlast)),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (cmd_out),
        .o_empty (q_empty)
    );

    sha_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_valid (!q_empty),
        .o_cmd_pop   (pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_word      (word),
        .o_index     (index),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, index, word};

    `ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, pop, !q_empty)
    `ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, index == 3'd7)
endmodule
`default_nettype wire

@@ tb/tb_sha256_stream_hasher_top.sv @@
// Self-checking testbench for the byte-stream SHA-256 hasher: random bytes, stalls and digest checks.
`default_nettype none
module tb_sha256_stream_hasher_top
    import sha_pkg::*;
();

    localparam int unsigned StallLimit = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte[7:0]
    logic        s_axis_tuser;   // has_byte
    logic        s_axis_tlast;   // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // digest_word[31:0], word_index[34:32], zeros
    logic        m_axis_tlast;   // last_word

    typedef struct packed {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_beat;

    t_cmd         pending_cmds[$];
    t_digest_beat expected_digest[$];
    t_hash        chain_hash;
    logic [7:0]   blk[64];
    int unsigned  blk_fill;
    logic [60:0]  msg_bytes;
    int unsigned  fails;
    int unsigned  quiet_cycles;
    int unsigned  hold_off;
    bit           no_idle;
    bit           sent_all;
    bit           drain_pause;
    bit           pause_armed;
    int unsigned  sent_cnt;

    sha256_stream_hasher_top dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_word rotr(t_word v, int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress_blk();
        t_word w[64];
        t_word a, b, c, d, e, f, g, h, t1, t2;
        t_word k[64];
        k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        a = chain_hash[0]; b = chain_hash[1]; c = chain_hash[2]; d = chain_hash[3];
        e = chain_hash[4]; f = chain_hash[5]; g = chain_hash[6]; h = chain_hash[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                + k[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
        chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
    endtask

    task automatic absorb_byte(logic [7:0] v);
        blk[blk_fill] = v;
        blk_fill = (blk_fill + 1) % 64;
        if (blk_fill == 0)
            compress_blk();
    endtask

    task automatic predict_digest(t_cmd c);
        logic [63:0] bits;
        if (c.has_byte) begin
            msg_bytes = msg_bytes + 1'b1;
            absorb_byte(c.data_byte);
        end
        if (c.is_last) begin
            bits = {msg_bytes, 3'b000};
            absorb_byte(PadByte);
            while (blk_fill != LenStart)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(bits[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++)
                expected_digest.insert(expected_digest.size(),
                    '{chain_hash[i], 3'(i), i == 7});
            chain_hash = InitHash;
            blk_fill = 0;
            msg_bytes = '0;
        end
    endtask

    task automatic queue_message(int unsigned len, bit noisy);
        t_cmd c;
        for (int i = 0; i < len; i++) begin
            c.data_byte = 8'($urandom);
            c.has_byte = 1'b1;
            c.is_last = (i == len - 1) && ($urandom_range(0, 1) == 1);
            if (noisy && $urandom_range(0, 5) == 0)
                c.has_byte = 1'b0;
            pending_cmds.insert(pending_cmds.size(), c);
        end
        if (len == 0 || !pending_cmds[$].is_last) begin
            c.data_byte = 8'($urandom);
            c.has_byte = 1'b0;
            c.is_last = 1'b1;
            pending_cmds.insert(pending_cmds.size(), c);
        end
    endtask

    initial begin
        int unsigned total;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        fails = 0;
        chain_hash = InitHash;
        blk_fill = 0;
        msg_bytes = '0;
        sent_all = 1'b0;
        // Empty message; byte with end in one beat; byte, ignored beat, byte, end; byte with end.
        pending_cmds.insert(pending_cmds.size(), '{8'hff, 1'b0, 1'b1});
        pending_cmds.insert(pending_cmds.size(), '{8'h61, 1'b1, 1'b1});
        pending_cmds.insert(pending_cmds.size(), '{8'h00, 1'b1, 1'b0});
        pending_cmds.insert(pending_cmds.size(), '{8'hff, 1'b0, 1'b0});
        pending_cmds.insert(pending_cmds.size(), '{8'hff, 1'b1, 1'b0});
        pending_cmds.insert(pending_cmds.size(), '{8'h55, 1'b0, 1'b1});
        pending_cmds.insert(pending_cmds.size(), '{8'haa, 1'b1, 1'b1});
        // Around the padding boundary: 55 and 56 bytes, then exactly one block.
        queue_message(55, 1'b0);
        queue_message(56, 1'b0);
        queue_message(64, 1'b0);
        total = pending_cmds.size();
        while (total < 270) begin
            case ($urandom_range(0, 5))
                0: queue_message($urandom_range(55, 65), 1'b0);
                1: queue_message($urandom_range(0, 3), 1'b1);
                default: queue_message($urandom_range(1, 40), $urandom_range(0, 3) == 0);
            endcase
            total = pending_cmds.size();
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Sender.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_digest({s_axis_tdata, s_axis_tuser, s_axis_tlast});
                sent_cnt++;
            end
            if (sent_cnt == 150 && !pause_armed) begin
                pause_armed = 1'b1;
                drain_pause = 1'b1;
            end
            if (drain_pause && expected_digest.size() == 0)
                drain_pause = 1'b0;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() != 0 && !drain_pause
                        && (no_idle || $urandom_range(0, 99) >= 28)) begin
                    {s_axis_tdata, s_axis_tuser, s_axis_tlast} <= pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (pending_cmds.size() == 0)
                        sent_all = 1'b1;
                end
            end
        end
    end

    // Receiver and checker.
    always @(posedge i_clk) begin
        t_digest_beat exp_b;
        if (i_rst_n) begin
            no_idle = (sent_cnt > 170 && sent_cnt < 250);
            if (m_axis_tvalid && m_axis_tready) begin
                quiet_cycles = 0;
                if (expected_digest.size() == 0) begin
                    $error("unexpected digest beat %h", m_axis_tdata);
                    fails++;
                end else begin
                    exp_b = expected_digest.pop_front();
                    if (m_axis_tdata[31:0] !== exp_b.word) begin
                        $error("digest_word exp %h got %h", exp_b.word, m_axis_tdata[31:0]);
                        fails++;
                    end
                    if (m_axis_tdata[34:32] !== exp_b.index) begin
                        $error("word_index exp %0d got %0d", exp_b.index, m_axis_tdata[34:32]);
                        fails++;
                    end
                    if (m_axis_tlast !== exp_b.last) begin
                        $error("last_word exp %0d got %0d", exp_b.last, m_axis_tlast);
                        fails++;
                    end
                end
            end else if (s_axis_tvalid && s_axis_tready) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (sent_cnt == 60 && hold_off == 0)
                hold_off = 600;
            if (hold_off > 1) begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_idle || $urandom_range(0, 99) >= 28;
            end
        end
    end

    initial begin
        hold_off = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        drain_pause = 1'b0;
        pause_armed = 1'b0;
        sent_cnt = 0;
        wait (i_rst_n);
        while (!(sent_all && !s_axis_tvalid && expected_digest.size() == 0)
                && quiet_cycles < StallLimit)
            @(posedge i_clk);
        if (quiet_cycles >= StallLimit) begin
            $display("sha256_stream_hasher_top regression: fail");
            $finish;
        end else begin
            repeat (300) @(posedge i_clk);
            if (fails == 0 && expected_digest.size() == 0)
                $display("sha256_stream_hasher_top regression: pass");
            else
                $display("sha256_stream_hasher_top regression: fail");
            $finish;
        end
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/sha_pkg.sv
sv/sha_queue.sv
sv/sha_core.sv
sv/sha256_stream_hasher_top.sv
tb/tb_sha256_stream_hasher_top.sv
